/* rtl/psf_pkg.sv */
// Shared types, register codes and fixed-point constants of the starfield step engine.
`default_nettype none

package psf_pkg;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_SCREEN_WIDTH  = 2'd0,
		CFG_SCREEN_HEIGHT = 2'd1,
		CFG_SPEED         = 2'd2,
		CFG_WINDOW_HEIGHT = 2'd3
	} cfg_reg_t;

	// Command codes
	localparam logic CMD_SEED = 1'b0;
	localparam logic CMD_STEP = 1'b1;

	// Register reset values
	localparam logic [12:0] RST_SCREEN_WIDTH  = 13'd1280;
	localparam logic [12:0] RST_SCREEN_HEIGHT = 13'd720;
	localparam logic [15:0] RST_SPEED         = 16'd512;
	localparam logic [12:0] RST_WINDOW_HEIGHT = 13'd1080;

	// Screen size limits
	localparam logic [12:0] SIZE_MIN = 13'd2;
	localparam logic [12:0] SIZE_MAX = 13'd4096;

	// Frame time cap: more than 125 whole ms takes the full speed
	localparam logic [19:0] ELAPSED_CAP = 20'd126000;

	// floor(t / 3125) = (t * RECIP_3125) >> 43 for t < 2^31
	localparam logic [31:0] RECIP_3125 = 32'd2814749768;
	// floor(n / 86400) = (n * RECIP_86400) >> 42 for n < 2^25
	localparam logic [25:0] RECIP_86400 = 26'd50903317;

	// Pipeline shape
	localparam int MOD_STAGES = 4;
	localparam int DIV_STAGES = 10;
	localparam int LATENCY    = 21;

	// Shade thresholds on the Q.8 radius
	localparam logic signed [25:0] SHADE_T3 = 26'sd2560;
	localparam logic signed [25:0] SHADE_T2 = 26'sd1920;
	localparam logic signed [25:0] SHADE_T1 = 26'sd1280;

	localparam logic [1:0] SHADE_63  = 2'd0;
	localparam logic [1:0] SHADE_127 = 2'd1;
	localparam logic [1:0] SHADE_191 = 2'd2;
	localparam logic [1:0] SHADE_255 = 2'd3;

	typedef struct packed {
		logic        cmd;
		logic [9:0]  star_index;
		logic [19:0] elapsed_us;
		logic [15:0] rand_x;
		logic [15:0] rand_y;
		logic [15:0] rand_depth;
	} psf_item_t;

	typedef struct packed {
		logic [9:0]         star_id;
		logic signed [15:0] screen_x;
		logic signed [15:0] screen_y;
		logic [7:0]         radius_q4;
		logic [1:0]         shade;
	} psf_result_t;

	// One table entry: position and Q12.8 depth
	typedef struct packed {
		logic signed [11:0] xpos;
		logic signed [11:0] ypos;
		logic [19:0]        depth;
	} psf_star_t;

	function automatic logic [12:0] clamp_size(input logic [12:0] v);
		if (v < SIZE_MIN) begin
			return SIZE_MIN;
		end else if (v > SIZE_MAX) begin
			return SIZE_MAX;
		end
		return v;
	endfunction

endpackage

`default_nettype wire

/* rtl/psf_div.sv */
// Pipelined restoring divider: unsigned quotient and remainder, a few bits per stage.
`default_nettype none

module psf_div #(
	parameter int NW     = 16,
	parameter int DW     = 13,
	parameter int STAGES = 4,
	parameter int SW     = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          vld_in,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] side_in,
	output logic          vld_out,
	output logic [NW-1:0] quo,
	output logic [DW-1:0] rem,
	output logic [SW-1:0] side_out
);

	localparam int BPS = (NW + STAGES - 1) / STAGES;
	localparam int TW  = BPS * STAGES;

	// dividend bits shift out at the top, quotient bits shift in at the bottom
	logic [TW-1:0]     num_sn  [STAGES];
	logic [DW-1:0]     rem_sn  [STAGES];
	logic [DW-1:0]     den_sn  [STAGES];
	logic [SW-1:0]     side_sn [STAGES];
	logic [STAGES-1:0] vld_sn;

	logic [TW-1:0] src_num [STAGES];
	logic [DW-1:0] src_rem [STAGES];
	logic [DW-1:0] src_den [STAGES];
	logic [SW-1:0] src_side[STAGES];
	logic [TW-1:0] num_nx  [STAGES];
	logic [DW-1:0] rem_nx  [STAGES];

	// stage inputs
	always_comb begin
		src_num[0]  = TW'(num);
		src_rem[0]  = '0;
		src_den[0]  = den;
		src_side[0] = side_in;
		for (int k = 1; k < STAGES; k++) begin
			src_num[k]  = num_sn[k-1];
			src_rem[k]  = rem_sn[k-1];
			src_den[k]  = den_sn[k-1];
			src_side[k] = side_sn[k-1];
		end
	end

	// BPS compare-subtract steps per stage
	always_comb begin
		logic [DW:0]   trial;
		logic [TW-1:0] n;
		logic [DW-1:0] r;
		for (int k = 0; k < STAGES; k++) begin
			n = src_num[k];
			r = src_rem[k];
			for (int b = 0; b < BPS; b++) begin
				trial = {r, n[TW-1]};
				n = n << 1;
				if (trial >= {1'b0, src_den[k]}) begin
					trial = trial - {1'b0, src_den[k]};
					n[0] = 1'b1;
				end
				r = trial[DW-1:0];
			end
			num_nx[k] = n;
			rem_nx[k] = r;
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sn <= '0;
		end else begin
			vld_sn <= {vld_sn[STAGES-2:0], vld_in};
		end
	end

	// payload
	always_ff @(posedge clk) begin
		for (int k = 0; k < STAGES; k++) begin
			num_sn[k]  <= num_nx[k];
			rem_sn[k]  <= rem_nx[k];
			den_sn[k]  <= src_den[k];
			side_sn[k] <= src_side[k];
		end
	end

	assign vld_out  = vld_sn[STAGES-1];
	assign quo      = num_sn[STAGES-1][NW-1:0];
	assign rem      = rem_sn[STAGES-1];
	assign side_out = side_sn[STAGES-1];

endmodule

`default_nettype wire

/* rtl/perspective_starfield_step.sv */
// Top level of the starfield step engine: star table, update and projection pipeline.
`default_nettype none

// Channel  | Handshake             | Word
// ---------+-----------------------+------------------------------------------
// item in  | start, busy           | item (cmd, star_index, elapsed_us, rands)
// result   | done (one-cycle pulse)| result (star_id, screen_x/y, radius, shade)
// config   | cfg_we                | cfg_idx, cfg_data
//
// One word is taken every cycle; busy stays low. A step word's result passes the
// spawn modulo (4 stages), the table read-modify-write, the parallel 10-stage
// dividers and the radius multiply. Back-to-back words on one star see each
// other through a one-deep bypass. Reset clears the valid bits and resets the
// config registers, not the table; a star must be seeded before it is stepped.

module perspective_starfield_step #(
	parameter int NUM_STARS = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  psf_pkg::psf_item_t   item,
	output logic                 done,
	output psf_pkg::psf_result_t result,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_idx,
	input  logic [15:0]          cfg_data
);

	import psf_pkg::*;

	localparam int AW = (NUM_STARS > 1) ? $clog2(NUM_STARS) : 1;

	// configuration
	logic [12:0] screen_width_q;
	logic [12:0] screen_height_q;
	logic [15:0] speed_q;
	logic [12:0] window_height_q;
	logic [12:0] wc;
	logic [12:0] hc;
	logic [11:0] w;
	logic [11:0] h;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= RST_SCREEN_WIDTH;
			screen_height_q <= RST_SCREEN_HEIGHT;
			speed_q         <= RST_SPEED;
			window_height_q <= RST_WINDOW_HEIGHT;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				CFG_SCREEN_WIDTH:  screen_width_q  <= cfg_data[12:0];
				CFG_SCREEN_HEIGHT: screen_height_q <= cfg_data[12:0];
				CFG_SPEED:         speed_q         <= cfg_data;
				CFG_WINDOW_HEIGHT: window_height_q <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	assign wc = clamp_size(screen_width_q);
	assign hc = clamp_size(screen_height_q);
	assign w  = wc[12:1];
	assign h  = hc[12:1];

	// input
	logic acc;
	logic in_range;

	assign busy     = 1'b0;
	assign acc      = start & ~busy;
	assign in_range = int'(item.star_index) < NUM_STARS;

	// spawn modulo, stages 1..4
	logic        v_s4;
	logic [10:0] side_s4;
	logic [12:0] rx_s4;
	logic [12:0] ry_s4;
	logic [12:0] rd_s4;

	psf_div #(.NW(16), .DW(13), .STAGES(MOD_STAGES), .SW(11)) u_mod_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld_in   (acc & in_range),
		.num      (item.rand_x),
		.den      (wc),
		.side_in  ({item.cmd, item.star_index}),
		.vld_out  (v_s4),
		.quo      (),
		.rem      (rx_s4),
		.side_out (side_s4)
	);

	psf_div #(.NW(16), .DW(13), .STAGES(MOD_STAGES), .SW(1)) u_mod_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld_in   (acc),
		.num      (item.rand_y),
		.den      (hc),
		.side_in  (1'b0),
		.vld_out  (),
		.quo      (),
		.rem      (ry_s4),
		.side_out ()
	);

	psf_div #(.NW(16), .DW(13), .STAGES(MOD_STAGES), .SW(1)) u_mod_d (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld_in   (acc),
		.num      (item.rand_depth),
		.den      (wc),
		.side_in  (1'b0),
		.vld_out  (),
		.quo      (),
		.rem      (rd_s4),
		.side_out ()
	);

	// depth decrement: speed * elapsed * 3 / 50000, or speed itself at the elapsed cap, stages 1..4
	logic [32:0] p_s1;
	logic        cap_s1;
	logic [30:0] t_s2;
	logic        cap_s2;
	logic [19:0] adjm_s3;
	logic        cap_s3;
	logic [19:0] adj_s4;
	logic [34:0] p3;
	logic [62:0] prod3;

	assign p3    = {1'b0, p_s1, 1'b0} + {2'b0, p_s1};
	assign prod3 = {32'd0, t_s2} * {31'd0, RECIP_3125};

	always_ff @(posedge clk) begin
		p_s1    <= {16'd0, speed_q} * {16'd0, item.elapsed_us[16:0]};
		cap_s1  <= item.elapsed_us >= ELAPSED_CAP;
		t_s2    <= p3[34:4];
		cap_s2  <= cap_s1;
		adjm_s3 <= prod3[62:43];
		cap_s3  <= cap_s2;
		adj_s4  <= cap_s3 ? {4'd0, speed_q} : adjm_s3;
	end

	// stage 5: table read-modify-write
	psf_star_t   star_mem [NUM_STARS];
	psf_star_t   star_rd_s5;
	logic        v_s5;
	logic        cmd_s5;
	logic [9:0]  idx_s5;
	logic [12:0] rx_s5;
	logic [12:0] ry_s5;
	logic [12:0] rd_s5;
	logic [19:0] adj_s5;

	logic        wr_s6;
	logic        rv_s6;
	logic [9:0]  idx_s6;
	psf_star_t   star_s6;

	psf_star_t          old_star;
	psf_star_t          new_star;
	logic signed [13:0] spx;
	logic signed [13:0] spy;
	logic signed [21:0] dn;
	logic               respawn;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s5     <= side_s4[10];
		idx_s5     <= side_s4[9:0];
		rx_s5      <= rx_s4;
		ry_s5      <= ry_s4;
		rd_s5      <= rd_s4;
		adj_s5     <= adj_s4;
		star_rd_s5 <= star_mem[AW'(side_s4[9:0])];
	end

	always_ff @(posedge clk) begin
		if (v_s5) begin
			star_mem[AW'(idx_s5)] <= new_star;
		end
	end

	always_comb begin
		// bypass the word written in the previous cycle
		if (wr_s6 && (idx_s6 == idx_s5)) begin
			old_star = star_s6;
		end else begin
			old_star = star_rd_s5;
		end
		spx     = $signed({1'b0, rx_s5}) - $signed({2'b0, w});
		spy     = $signed({1'b0, ry_s5}) - $signed({2'b0, h});
		dn      = $signed({2'b0, old_star.depth}) - $signed({2'b0, adj_s5});
		respawn = dn < 22'sd256;
		if (cmd_s5 == CMD_SEED) begin
			new_star.xpos  = spx[11:0];
			new_star.ypos  = spy[11:0];
			new_star.depth = {rd_s5[12:1], 8'd0};
		end else if (respawn) begin
			new_star.xpos  = spx[11:0];
			new_star.ypos  = spy[11:0];
			new_star.depth = {w, 8'd0};
		end else begin
			new_star.xpos  = old_star.xpos;
			new_star.ypos  = old_star.ypos;
			new_star.depth = dn[19:0];
		end
	end

	// stage 6
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_s6 <= 1'b0;
			rv_s6 <= 1'b0;
		end else begin
			wr_s6 <= v_s5;
			rv_s6 <= v_s5 && (cmd_s5 == CMD_STEP);
		end
	end

	always_ff @(posedge clk) begin
		idx_s6  <= idx_s5;
		star_s6 <= new_star;
	end

	// stage 7: position magnitudes times half size
	logic [12:0] ax;
	logic [12:0] ay;
	logic        rv_s7;
	logic [9:0]  idx_s7;
	logic        sgnx_s7;
	logic        sgny_s7;
	logic [23:0] mx_s7;
	logic [23:0] my_s7;
	logic [19:0] d_s7;

	assign ax = star_s6.xpos[11] ? (13'd0 - {star_s6.xpos[11], star_s6.xpos})
	                             : {1'b0, star_s6.xpos};
	assign ay = star_s6.ypos[11] ? (13'd0 - {star_s6.ypos[11], star_s6.ypos})
	                             : {1'b0, star_s6.ypos};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_s7 <= 1'b0;
		end else begin
			rv_s7 <= rv_s6;
		end
	end

	always_ff @(posedge clk) begin
		idx_s7  <= idx_s6;
		sgnx_s7 <= star_s6.xpos[11];
		sgny_s7 <= star_s6.ypos[11];
		mx_s7   <= {12'd0, ax[11:0]} * {12'd0, w};
		my_s7   <= {12'd0, ay[11:0]} * {12'd0, h};
		d_s7    <= star_s6.depth;
	end

	// stages 8..17: projection and radius dividers
	logic        v_s17;
	logic [11:0] side_s17;
	logic [39:0] qx_s17;
	logic [19:0] rmx_s17;
	logic [39:0] qy_s17;
	logic [19:0] rmy_s17;
	logic [23:0] qr_s17;

	psf_div #(.NW(40), .DW(20), .STAGES(DIV_STAGES), .SW(12)) u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld_in   (rv_s7),
		.num      ({mx_s7, 16'd0}),
		.den      (d_s7),
		.side_in  ({idx_s7, sgnx_s7, sgny_s7}),
		.vld_out  (v_s17),
		.quo      (qx_s17),
		.rem      (rmx_s17),
		.side_out (side_s17)
	);

	psf_div #(.NW(40), .DW(20), .STAGES(DIV_STAGES), .SW(1)) u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld_in   (rv_s7),
		.num      ({my_s7, 16'd0}),
		.den      (d_s7),
		.side_in  (1'b0),
		.vld_out  (),
		.quo      (qy_s17),
		.rem      (rmy_s17),
		.side_out ()
	);

	psf_div #(.NW(24), .DW(12), .STAGES(DIV_STAGES), .SW(1)) u_div_r (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld_in   (rv_s7),
		.num      ({d_s7, 4'd0}),
		.den      (w),
		.side_in  (1'b0),
		.vld_out  (),
		.quo      (qr_s17),
		.rem      (),
		.side_out ()
	);

	// stage 18: floor signs and radius
	logic [33:0] magx;
	logic [33:0] magy;
	logic [33:0] sx8;
	logic [33:0] sy8;

	logic               v_s18;
	logic [9:0]         idx_s18;
	logic signed [33:0] sx8_s18;
	logic signed [33:0] sy8_s18;
	logic signed [25:0] r8_s18;

	assign magx = {2'b0, qx_s17[31:0]};
	assign magy = {2'b0, qy_s17[31:0]};
	assign sx8  = side_s17[1] ? (34'd0 - magx - {33'd0, |rmx_s17}) : magx;
	assign sy8  = side_s17[0] ? (34'd0 - magy - {33'd0, |rmy_s17}) : magy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s18 <= 1'b0;
		end else begin
			v_s18 <= v_s17;
		end
	end

	always_ff @(posedge clk) begin
		idx_s18 <= side_s17[11:2];
		sx8_s18 <= sx8;
		sy8_s18 <= sy8;
		r8_s18  <= $signed(26'd4096 - {2'b0, qr_s17});
	end

	// stage 19: screen corner, shade, radius product
	function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
		if (v > 36'sd32767) begin
			return 16'sh7fff;
		end else if (v < -36'sd32768) begin
			return 16'sh8000;
		end
		return v[15:0];
	endfunction

	logic signed [35:0] sumx;
	logic signed [35:0] sumy;
	logic [12:0]        rpos;
	logic [1:0]         shade_c;

	logic               v_s19;
	logic [9:0]         idx_s19;
	logic signed [15:0] scrx_s19;
	logic signed [15:0] scry_s19;
	logic [1:0]         shade_s19;
	logic [25:0]        prw_s19;

	always_comb begin
		sumx = $signed({sx8_s18[33], sx8_s18, 1'b0}) - $signed({{10{r8_s18[25]}}, r8_s18})
		     + $signed({15'd0, w, 9'd0});
		sumy = $signed({sy8_s18[33], sy8_s18, 1'b0}) - $signed({{10{r8_s18[25]}}, r8_s18})
		     + $signed({15'd0, h, 9'd0});
		rpos = (r8_s18 > 26'sd0) ? r8_s18[12:0] : 13'd0;
		if (r8_s18 > SHADE_T3) begin
			shade_c = SHADE_255;
		end else if (r8_s18 > SHADE_T2) begin
			shade_c = SHADE_191;
		end else if (r8_s18 > SHADE_T1) begin
			shade_c = SHADE_127;
		end else begin
			shade_c = SHADE_63;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s19 <= 1'b0;
		end else begin
			v_s19 <= v_s18;
		end
	end

	always_ff @(posedge clk) begin
		idx_s19   <= idx_s18;
		scrx_s19  <= sat16(sumx >>> 9);
		scry_s19  <= sat16(sumy >>> 9);
		shade_s19 <= shade_c;
		prw_s19   <= {13'd0, rpos} * {13'd0, window_height_q};
	end

	// stage 20: divide by 86400 through the reciprocal
	logic [51:0] prod19;

	logic               v_s20;
	logic [9:0]         idx_s20;
	logic signed [15:0] scrx_s20;
	logic signed [15:0] scry_s20;
	logic [1:0]         shade_s20;
	logic [9:0]         rq_s20;

	assign prod19 = {26'd0, prw_s19} * {26'd0, RECIP_86400};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s20 <= 1'b0;
		end else begin
			v_s20 <= v_s19;
		end
	end

	always_ff @(posedge clk) begin
		idx_s20   <= idx_s19;
		scrx_s20  <= scrx_s19;
		scry_s20  <= scry_s19;
		shade_s20 <= shade_s19;
		rq_s20    <= prod19[51:42];
	end

	// stage 21: output register
	logic        done_s21;
	psf_result_t res_s21;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s21 <= 1'b0;
		end else begin
			done_s21 <= v_s20;
		end
	end

	always_ff @(posedge clk) begin
		res_s21.star_id   <= idx_s20;
		res_s21.screen_x  <= scrx_s20;
		res_s21.screen_y  <= scry_s20;
		res_s21.radius_q4 <= (rq_s20 > 10'd255) ? 8'd255 : rq_s20[7:0];
		res_s21.shade     <= shade_s20;
	end

	assign done   = done_s21;
	assign result = res_s21;

endmodule

`default_nettype wire

/* rtl/psf_check.sv */
// Port-level checker for the starfield step engine, bound to the top level.
`default_nettype none

module psf_check #(
	parameter int NUM_STARS = 1024
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 start,
	input logic                 busy,
	input psf_pkg::psf_item_t   item,
	input logic                 done,
	input psf_pkg::psf_result_t result
);

	import psf_pkg::*;

	// the engine never holds off a word
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy == 1'b0)
		else $error("busy asserted");

	// every in-range step word gives a result after the fixed latency
	a_step_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.cmd == CMD_STEP && int'(item.star_index) < NUM_STARS)
		|-> ##LATENCY done)
		else $error("step word lost");

	// no result appears without a step word accepted before it
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy && item.cmd == CMD_STEP, LATENCY))
		else $error("result without step word");

	// the result carries the index of its step word
	a_star_id: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.star_id == $past(item.star_index, LATENCY))
		else $error("star_id mismatch");

endmodule

bind perspective_starfield_step psf_check #(.NUM_STARS(NUM_STARS)) u_psf_check (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.item   (item),
	.done   (done),
	.result (result)
);

`default_nettype wire

/* test/testbench.sv */
// Self-checking testbench for the starfield step engine: star seed, advance and projection.
module testbench;
	import psf_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	psf_item_t   item;
	logic        done;
	psf_result_t result;
	logic        cfg_we;
	logic [1:0]  cfg_idx;
	logic [15:0] cfg_data;

	perspective_starfield_step i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	// Predictor copy of registers and star table
	logic [12:0]        width_reg, height_reg, winh_reg;
	logic [15:0]        speed_reg;
	logic signed [11:0] star_x [1024];
	logic signed [11:0] star_y [1024];
	logic [19:0]        star_z [1024];
	bit                 seeded [1024];

	psf_result_t projections[$];
	int          fail_count;
	int          steps_sent, seeds_sent, results_seen;
	longint      cycle_count;
	bit          no_idle;

	// Directed stimulus rows
	typedef struct {
		psf_item_t   it;
		bit          typed;
		psf_result_t want;
	} dir_row_t;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint fit_size(logic [12:0] v);
		if (v < 13'd2) return 2;
		if (v > 13'd4096) return 4096;
		return longint'(v);
	endfunction

	function automatic longint fdiv(longint n, longint d);
		longint q;
		q = n / d;
		if ((n % d) != 0 && n < 0) q--;
		return q;
	endfunction

	function automatic logic [15:0] clip16(longint v);
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return v[15:0];
	endfunction

	// Advance or seed one star; returns 1 with the projection for a step word
	function automatic bit project_star(psf_item_t it, output psf_result_t r);
		longint wf, hf, w, h, adj, d, r8, sx8, sy8, rq;
		int i;
		i = it.star_index;
		wf = fit_size(width_reg);
		hf = fit_size(height_reg);
		w = wf / 2;
		h = hf / 2;
		r = '0;
		if (it.cmd == CMD_SEED) begin
			star_x[i] = 12'(longint'(it.rand_x) % wf - w);
			star_y[i] = 12'(longint'(it.rand_y) % hf - h);
			star_z[i] = 20'(((longint'(it.rand_depth) % wf) / 2) * 256);
			return 1'b0;
		end
		if (it.elapsed_us >= ELAPSED_CAP) adj = longint'(speed_reg);
		else adj = (longint'(speed_reg) * longint'(it.elapsed_us) * 60) / 1000000;
		d = longint'(star_z[i]) - adj;
		// past depth 1.0: respawn at the far plane
		if (d < 256) begin
			d = w * 256;
			star_x[i] = 12'(longint'(it.rand_x) % wf - w);
			star_y[i] = 12'(longint'(it.rand_y) % hf - h);
		end
		star_z[i] = d[19:0];
		r8 = 4096 - (d * 16) / w;
		sx8 = fdiv(longint'(star_x[i]) * w * 65536, d);
		sy8 = fdiv(longint'(star_y[i]) * h * 65536, d);
		rq = (r8 > 0) ? (r8 * longint'(winh_reg)) / 86400 : 0;
		if (rq > 255) rq = 255;
		r.star_id = it.star_index;
		r.screen_x = clip16(fdiv(2 * sx8 - r8 + w * 512, 512));
		r.screen_y = clip16(fdiv(2 * sy8 - r8 + h * 512, 512));
		r.radius_q4 = rq[7:0];
		if (r8 > 2560) r.shade = SHADE_255;
		else if (r8 > 1920) r.shade = SHADE_191;
		else if (r8 > 1280) r.shade = SHADE_127;
		else r.shade = SHADE_63;
		return 1'b1;
	endfunction

	// Result checker: compare every strobed word with the oldest projection
	always @(posedge clk) begin
		psf_result_t exp_r;
		if (arst_n && done) begin
			results_seen++;
			if (projections.size() == 0) begin
				$error("unexpected result word: %p", result);
				fail_count++;
			end else begin
				exp_r = projections.pop_front();
				if (result.star_id !== exp_r.star_id) begin
					$error("star_id expected %0d actual %0d", exp_r.star_id, result.star_id);
					fail_count++;
				end
				if (result.screen_x !== exp_r.screen_x) begin
					$error("screen_x expected %0d actual %0d", exp_r.screen_x, result.screen_x);
					fail_count++;
				end
				if (result.screen_y !== exp_r.screen_y) begin
					$error("screen_y expected %0d actual %0d", exp_r.screen_y, result.screen_y);
					fail_count++;
				end
				if (result.radius_q4 !== exp_r.radius_q4) begin
					$error("radius_q4 expected %0d actual %0d", exp_r.radius_q4,
						result.radius_q4);
					fail_count++;
				end
				if (result.shade !== exp_r.shade) begin
					$error("shade expected %0d actual %0d", exp_r.shade, result.shade);
					fail_count++;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	// Send one word; start stays high across back-to-back words
	task automatic send_word(psf_item_t it, bit typed, psf_result_t want);
		psf_result_t r;
		if (!no_idle && $urandom_range(99) < 3) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		start <= 1'b1;
		item <= it;
		@(posedge clk);
		while (busy) @(posedge clk);
		if (it.cmd == CMD_SEED) seeds_sent++;
		else steps_sent++;
		seeded[it.star_index] = 1'b1;
		if (project_star(it, r)) projections.push_back(typed ? want : r);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (projections.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t r, logic [15:0] v);
		cfg_we <= 1'b1;
		cfg_idx <= r;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (r)
			CFG_SCREEN_WIDTH: begin
				width_reg = v[12:0];
			end
			CFG_SCREEN_HEIGHT: begin
				height_reg = v[12:0];
			end
			CFG_SPEED: begin
				speed_reg = v;
			end
			default: begin
				winh_reg = v[12:0];
			end
		endcase
	endtask

	task automatic set_screen(logic [15:0] wv, logic [15:0] hv, logic [15:0] sp,
			logic [15:0] wh);
		write_reg(CFG_SCREEN_WIDTH, wv);
		write_reg(CFG_SCREEN_HEIGHT, hv);
		write_reg(CFG_SPEED, sp);
		write_reg(CFG_WINDOW_HEIGHT, wh);
	endtask

	function automatic psf_item_t make_word(bit c, int idx, int el, int rx, int ry, int rd);
		psf_item_t it;
		it.cmd = c ? CMD_STEP : CMD_SEED;
		it.star_index = 10'(idx);
		it.elapsed_us = 20'(el);
		it.rand_x = 16'(rx);
		it.rand_y = 16'(ry);
		it.rand_depth = 16'(rd);
		return it;
	endfunction

	// Random word: mostly steps on a small pool of seeded stars
	task automatic random_burst(int n, bit pause_midway);
		psf_item_t it;
		psf_result_t none;
		int idx, pick;
		none = '0;
		for (int k = 0; k < n; k++) begin
			if (pause_midway && k == n / 2) drain();
			idx = ($urandom_range(9) < 8) ? $urandom_range(31) : $urandom_range(1023);
			pick = $urandom_range(9);
			it.cmd = (seeded[idx] && pick < 7) ? CMD_STEP : CMD_SEED;
			it.star_index = 10'(idx);
			case ($urandom_range(3))
				0: it.elapsed_us = 20'($urandom_range(20000));
				1: it.elapsed_us = 20'($urandom_range(125990, 126010));
				2: it.elapsed_us = 20'($urandom);
				default: it.elapsed_us = 20'($urandom_range(1));
			endcase
			it.rand_x = 16'($urandom);
			it.rand_y = 16'($urandom);
			it.rand_depth = ($urandom_range(3) == 0) ? 16'($urandom_range(3)) : 16'($urandom);
			send_word(it, 1'b0, none);
		end
	endtask

	initial begin
		dir_row_t dir_rows[$];
		dir_row_t row;
		psf_result_t none;
		none = '0;
		fail_count = 0;
		steps_sent = 0;
		seeds_sent = 0;
		results_seen = 0;
		cycle_count = 0;
		no_idle = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_idx = CFG_SCREEN_WIDTH;
		cfg_data = '0;
		width_reg = RST_SCREEN_WIDTH;
		height_reg = RST_SCREEN_HEIGHT;
		speed_reg = RST_SPEED;
		winh_reg = RST_WINDOW_HEIGHT;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed table, reset settings: star 0 at zero depth respawns dead center
		row.typed = 1'b0;
		row.want = none;
		row.it = make_word(0, 0, 0, 640, 360, 0);
		dir_rows.push_back(row);
		row.it = make_word(1, 0, 0, 640, 360, 0);
		row.typed = 1'b1;
		row.want = '{star_id: 10'd0, screen_x: 16'sd640, screen_y: 16'sd360,
			radius_q4: 8'd0, shade: SHADE_63};
		dir_rows.push_back(row);
		row.typed = 1'b0;
		row.want = none;
		row.it = make_word(0, 1023, 0, 65535, 65535, 65535);
		dir_rows.push_back(row);
		row.it = make_word(1, 1023, 125999, 0, 0, 0);
		dir_rows.push_back(row);
		row.it = make_word(1, 1023, 126000, 65535, 0, 65535);
		dir_rows.push_back(row);
		row.it = make_word(1, 1023, 1048575, 0, 65535, 0);
		dir_rows.push_back(row);
		row.it = make_word(0, 5, 0, 0, 0, 1279);
		dir_rows.push_back(row);
		for (int k = 0; k < 12; k++) begin
			row.it = make_word(1, 5, 125000, 1279, 719, 0);
			dir_rows.push_back(row);
		end
		row.it = make_word(0, 682, 1, 21845, 43690, 2);
		dir_rows.push_back(row);
		row.it = make_word(1, 682, 699050, 43690, 21845, 21845);
		dir_rows.push_back(row);
		foreach (dir_rows[k]) send_word(dir_rows[k].it, dir_rows[k].typed, dir_rows[k].want);
		drain();

		// Settings phases, extremes included; stars keep depths across size changes
		set_screen(16'd2, 16'd2, 16'd0, 16'd1);
		random_burst(110, 1'b0);
		drain();
		set_screen(16'd4096, 16'd4096, 16'd65535, 16'd4096);
		no_idle = 1'b1;
		random_burst(130, 1'b0);
		no_idle = 1'b0;
		drain();
		set_screen(16'hFFFF, 16'd0, 16'd40000, 16'h1FFF);
		random_burst(110, 1'b1);
		drain();
		set_screen(16'd1, 16'd8191, 16'd1, 16'd4095);
		random_burst(100, 1'b0);
		drain();
		set_screen(16'd1280, 16'd720, 16'd512, 16'd1080);
		random_burst(130, 1'b0);
		drain();
		set_screen(16'($urandom_range(2, 4096)), 16'($urandom_range(2, 4096)),
			16'($urandom), 16'($urandom_range(1, 4096)));
		random_burst(150, 1'b0);
		drain();

		$display("run: %0d seed words, %0d step words, %0d projections checked",
			seeds_sent, steps_sent, results_seen);
		$display("run: seven register settings incl. size, speed and window extremes");
		if (fail_count == 0 && projections.size() == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule
